// ----- rtl/lsig_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsig_pkg
// Shared constants, types and helper functions for the SIGNAL header decoder.
// ----------------------------------------------------------------------------
package lsig_pkg;

  localparam int unsigned NumStates  = 64;
  localparam int unsigned NumSteps   = 24;
  localparam int unsigned NumCoded   = 48;
  localparam int unsigned StateW     = 6;
  localparam int unsigned StepW      = 5;
  localparam int unsigned MetricW    = 6;
  localparam int unsigned DivW       = 16;
  localparam logic [6:0]  GenA       = 7'o133;
  localparam logic [6:0]  GenB       = 7'o171;
  localparam logic [StepW-1:0] LastStep = 5'(NumSteps - 1);

  // rate codes, LSB-first value of decoded bits 0..3
  localparam logic [3:0] Rate6  = 4'hB;
  localparam logic [3:0] Rate9  = 4'hF;
  localparam logic [3:0] Rate12 = 4'hA;
  localparam logic [3:0] Rate18 = 4'hE;
  localparam logic [3:0] Rate24 = 4'h9;
  localparam logic [3:0] Rate36 = 4'hD;
  localparam logic [3:0] Rate48 = 4'h8;
  localparam logic [3:0] Rate54 = 4'hC;

  typedef struct packed {
    logic [5:0] mbps;
    logic [7:0] ndbps;
  } rate_info_t;

  // metric memory word
  typedef struct packed {
    logic               reach;
    logic [MetricW-1:0] metric;
  } pm_entry_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_DECODE,
    CTL_DIV,
    CTL_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    TRL_IDLE,
    TRL_ACS,
    TRL_DRAIN,
    TRL_TB_REQ,
    TRL_TB_WAIT
  } trl_state_t;

  function automatic rate_info_t rate_lookup(input logic [3:0] code);
    rate_info_t r;
    unique case (code)
      Rate6:   r = '{mbps: 6'd6,  ndbps: 8'd24};
      Rate9:   r = '{mbps: 6'd9,  ndbps: 8'd36};
      Rate12:  r = '{mbps: 6'd12, ndbps: 8'd48};
      Rate18:  r = '{mbps: 6'd18, ndbps: 8'd72};
      Rate24:  r = '{mbps: 6'd24, ndbps: 8'd96};
      Rate36:  r = '{mbps: 6'd36, ndbps: 8'd144};
      Rate48:  r = '{mbps: 6'd48, ndbps: 8'd192};
      Rate54:  r = '{mbps: 6'd54, ndbps: 8'd216};
      default: r = '{mbps: 6'd0,  ndbps: 8'd0};
    endcase
    return r;
  endfunction

  // block deinterleave: out[k] = in[3*(k%16) + k/16]
  function automatic logic [NumCoded-1:0] deinterleave(input logic [NumCoded-1:0] din);
    logic [NumCoded-1:0] d;
    for (int k = 0; k < NumCoded; k++) begin
      d[k] = din[3 * (k % 16) + k / 16];
    end
    return d;
  endfunction

endpackage

// ----- rtl/lsig_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsig_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsig_div
  import lsig_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [7:0]      divisor,
  output logic            done,
  output logic [DivW-1:0] quotient
);

  logic            running;
  logic [3:0]      cnt;
  logic [DivW-1:0] quo;
  logic [7:0]      rem;
  logic [7:0]      dsr;
  logic [8:0]      trial;
  logic            fits;

  // shift in next dividend bit and try a subtract
  assign trial = {rem, quo[DivW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(DivW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      rem <= fits ? 8'(trial - {1'b0, dsr}) : trial[7:0];
      quo <= {quo[DivW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/lsig_trellis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsig_trellis
// Viterbi add-compare-select over a ping-pong path metric memory, survivor
// bits in a second memory, and a traceback from state 0.
// ----------------------------------------------------------------------------
module lsig_trellis
  import lsig_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumCoded-1:0] coded,
  output logic                done,
  output logic [NumSteps-1:0] word
);

  trl_state_t state, state_next;

  // memories
  pm_entry_t pm_mem [0:2*NumStates-1];
  logic      sv_mem [0:NumSteps*NumStates-1];
  pm_entry_t pm_rd0, pm_rd1;
  logic      sv_rd;

  logic [StepW-1:0]  step;
  logic [StateW-1:0] n;
  logic              acs_v;
  logic [StepW-1:0]  acs_step;
  logic [StateW-1:0] acs_n;
  logic [StepW-1:0]  tb_step;
  logic [StateW-1:0] tb_st;
  logic [NumCoded-1:0] cbits;

  logic              rd_issue;
  logic [StateW-1:0] p0, p1;
  logic [StateW-1:0] ap0, ap1;
  logic [6:0]        sr0, sr1;
  logic              r0, r1;
  logic [1:0]        bm0, bm1;
  pm_entry_t         c0, c1, new_pm;
  logic [MetricW-1:0] m0, m1;
  logic              sel1;

  // next state
  always_comb begin
    state_next = state;
    rd_issue   = 1'b0;
    unique case (state)
      TRL_IDLE: begin
        if (start) state_next = TRL_ACS;
      end
      TRL_ACS: begin
        rd_issue = 1'b1;
        if (step == LastStep && n == StateW'(NumStates - 1)) state_next = TRL_DRAIN;
      end
      TRL_DRAIN:   state_next = TRL_TB_REQ;
      TRL_TB_REQ:  state_next = TRL_TB_WAIT;
      TRL_TB_WAIT: begin
        if (tb_step == '0) state_next = TRL_IDLE;
        else               state_next = TRL_TB_REQ;
      end
      default: state_next = TRL_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRL_IDLE;
      acs_v <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      acs_v <= rd_issue;
      done  <= (state == TRL_TB_WAIT) && (tb_step == '0);
    end
  end

  // sequencing counters
  always_ff @(posedge clk) begin
    if (state == TRL_IDLE && start) begin
      cbits <= coded;
      step  <= '0;
      n     <= '0;
    end else if (rd_issue) begin
      n <= n + 1'b1;
      if (n == StateW'(NumStates - 1)) step <= step + 1'b1;
    end
    acs_step <= step;
    acs_n    <= n;
    if (state == TRL_DRAIN) begin
      tb_step <= LastStep;
      tb_st   <= '0;
    end else if (state == TRL_TB_WAIT) begin
      word[tb_step] <= tb_st[StateW-1];
      tb_st         <= {tb_st[StateW-2:0], sv_rd};
      tb_step       <= tb_step - 1'b1;
    end
  end

  // predecessor addresses for the issued state
  assign p0 = {n[StateW-2:0], 1'b0};
  assign p1 = {n[StateW-2:0], 1'b1};

  // path metric memory, bank chosen by step parity
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pm_rd0 <= pm_mem[{step[0], p0}];
      pm_rd1 <= pm_mem[{step[0], p1}];
    end
    if (acs_v) pm_mem[{~acs_step[0], acs_n}] <= new_pm;
  end

  // survivor memory
  always_ff @(posedge clk) begin
    if (acs_v) sv_mem[{acs_step, acs_n}] <= sel1;
    if (state == TRL_TB_REQ) sv_rd <= sv_mem[{tb_step, tb_st}];
  end

  // branch metrics
  assign ap0 = {acs_n[StateW-2:0], 1'b0};
  assign ap1 = {acs_n[StateW-2:0], 1'b1};
  assign sr0 = {acs_n[StateW-1], ap0};
  assign sr1 = {acs_n[StateW-1], ap1};
  assign r0  = cbits[{acs_step, 1'b0}];
  assign r1  = cbits[{acs_step, 1'b1}];
  assign bm0 = 2'((^(sr0 & GenA)) != r0) + 2'((^(sr0 & GenB)) != r1);
  assign bm1 = 2'((^(sr1 & GenA)) != r0) + 2'((^(sr1 & GenB)) != r1);

  // first step starts from state 0 alone
  always_comb begin
    if (acs_step == '0) begin
      c0 = '{reach: (ap0 == '0), metric: '0};
      c1 = '{reach: 1'b0, metric: '0};
    end else begin
      c0 = pm_rd0;
      c1 = pm_rd1;
    end
  end

  // add compare select, ties keep the lower predecessor
  assign m0     = c0.metric + MetricW'(bm0);
  assign m1     = c1.metric + MetricW'(bm1);
  assign sel1   = c1.reach && (!c0.reach || (m1 < m0));
  assign new_pm = '{reach: c0.reach | c1.reach, metric: sel1 ? m1 : m0};

endmodule

// ----- rtl/lsig_header_bit_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsig_header_bit_decoder
// SIGNAL header decoder: deinterleave, K=7 Viterbi decode and field checks.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result is shown on the output ports for one cycle with done
// high. The result cannot be held off, so it must be sampled in that cycle.
// A header with front_end_ok low gives an all-zero result in the cycle right
// after it is taken. Otherwise the add-compare-select updates one trellis
// state per cycle against the path metric memory for 24 steps of 64 states,
// a drain state lets the last write land, traceback reads one survivor bit
// per decoded bit from state 0 in a request and a wait state, and the word
// passes through the trellis done register into the result registers; a
// valid header then adds a serial division for the symbol count.
// ----------------------------------------------------------------------------
module lsig_header_bit_decoder
  import lsig_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [NumCoded-1:0] interleaved_bits,
  input  logic                front_end_ok,
  output logic                done,
  output logic [23:0]         decoded_word,
  output logic [3:0]          rate_code,
  output logic [11:0]         psdu_length,
  output logic                parity_ok,
  output logic                tail_ok,
  output logic [5:0]          rate_mbit,
  output logic                rate_ok,
  output logic                length_ok,
  output logic [10:0]         symbol_count,
  output logic                header_ok
);

  ctl_state_t state, state_next;

  logic                accept;
  logic                trl_start, trl_done;
  logic [NumSteps-1:0] trl_word;
  logic                div_start, div_done;
  logic [DivW-1:0]     div_q;
  logic [DivW-1:0]     div_num;
  logic [7:0]          ndbps;

  rate_info_t          ri;
  logic [11:0]         len;
  logic                par_ok, tl_ok, rt_ok, ln_ok, hdr_ok;

  assign accept    = start && !busy;
  assign busy      = (state != CTL_IDLE);
  assign done      = (state == CTL_OUT);
  assign trl_start = accept && front_end_ok;

  // field checks on the decoded word
  assign ri     = rate_lookup(trl_word[3:0]);
  assign len    = trl_word[16:5];
  assign par_ok = ~^trl_word[17:0];
  assign tl_ok  = (trl_word[23:18] == '0);
  assign rt_ok  = (ri.mbps != '0);
  assign ln_ok  = (len != '0);
  assign hdr_ok = par_ok && tl_ok && rt_ok && ln_ok;

  // next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      CTL_IDLE: begin
        if (accept) state_next = front_end_ok ? CTL_DECODE : CTL_OUT;
      end
      CTL_DECODE: begin
        if (trl_done) begin
          if (hdr_ok) begin
            div_start  = 1'b1;
            state_next = CTL_DIV;
          end else begin
            state_next = CTL_OUT;
          end
        end
      end
      CTL_DIV: begin
        if (div_done) state_next = CTL_OUT;
      end
      CTL_OUT: state_next = CTL_IDLE;
      default: state_next = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= CTL_IDLE;
    else     state <= state_next;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept && !front_end_ok) begin
      decoded_word <= '0;
      rate_code    <= '0;
      psdu_length  <= '0;
      parity_ok    <= 1'b0;
      tail_ok      <= 1'b0;
      rate_mbit    <= '0;
      rate_ok      <= 1'b0;
      length_ok    <= 1'b0;
      symbol_count <= '0;
      header_ok    <= 1'b0;
    end else if (state == CTL_DECODE && trl_done) begin
      decoded_word <= trl_word;
      rate_code    <= trl_word[3:0];
      psdu_length  <= len;
      parity_ok    <= par_ok;
      tail_ok      <= tl_ok;
      rate_mbit    <= ri.mbps;
      rate_ok      <= rt_ok;
      length_ok    <= ln_ok;
      symbol_count <= '0;
      header_ok    <= hdr_ok;
    end else if (state == CTL_DIV && div_done) begin
      symbol_count <= div_q[10:0];
    end
  end

  // ceil((22 + 8*length) / ndbps) as floor of a biased numerator
  assign ndbps   = ri.ndbps;
  assign div_num = DivW'(22) + {1'b0, len, 3'b000} + DivW'(ndbps) - DivW'(1);

  lsig_trellis u_trellis (
    .clk   (clk),
    .rst   (rst),
    .start (trl_start),
    .coded (deinterleave(interleaved_bits)),
    .done  (trl_done),
    .word  (trl_word)
  );

  lsig_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (ndbps),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ----- rtl/lsig_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsig_chk
// Port-level checks for the SIGNAL header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lsig_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        parity_ok,
  input logic        tail_ok,
  input logic        rate_ok,
  input logic        length_ok,
  input logic [10:0] symbol_count,
  input logic        header_ok
);

  // a result belongs to a transaction in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // one cycle per result
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");

  // header ok implies every check passed and a symbol count
  a_hdr_checks: assert property (@(posedge clk) disable iff (rst)
    (done && header_ok) |-> (parity_ok && tail_ok && rate_ok && length_ok
                             && symbol_count != 11'd0))
    else $error("header ok with a failed check");

  // no symbol count for a failed header
  a_nsym_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !header_ok) |-> (symbol_count == 11'd0))
    else $error("symbol count on failed header");

endmodule

bind lsig_header_bit_decoder lsig_chk u_lsig_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .parity_ok    (parity_ok),
  .tail_ok      (tail_ok),
  .rate_ok      (rate_ok),
  .length_ok    (length_ok),
  .symbol_count (symbol_count),
  .header_ok    (header_ok)
);
